FILE: sv/vpc_pkg.sv
// Shared constants, codes and helpers for the voxel placement checker.
package vpc_pkg;

  localparam int unsigned MAX_SIDE   = 16;
  localparam int unsigned GRID_CELLS = 4096;
  localparam int unsigned MAX_BLOCKS = 8;
  localparam int unsigned MAX_PIECES = 16;

  localparam int unsigned COORD_W    = 5;
  localparam int unsigned BOX_W      = 5;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned PIECES_W   = 5;
  localparam int unsigned CFG_ADDR_W = 2;

  localparam logic [BOX_W-1:0] BOX_RESET = BOX_W'(16);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_BOX_WIDTH,
    REG_BOX_HEIGHT,
    REG_BOX_DEPTH
  } cfg_reg_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_PLACED,
    ST_OUT_OF_BOX,
    ST_OVERLAP,
    ST_CAPACITY,
    ST_REMOVED,
    ST_NOTHING
  } status_e;

  function automatic int unsigned addr_w(int unsigned depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

FILE: sv/vpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module vpc_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW = vpc_pkg::addr_w(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/vpc_cell.sv
// Cell index and box containment check for one block.
module vpc_cell #(
  parameter int unsigned MAX_SIDE   = vpc_pkg::MAX_SIDE,
  parameter int unsigned GRID_CELLS = vpc_pkg::GRID_CELLS,
  localparam int unsigned CELL_W = vpc_pkg::addr_w(GRID_CELLS)
) (
  input  logic signed [vpc_pkg::COORD_W-1:0] block_x_i,
  input  logic signed [vpc_pkg::COORD_W-1:0] block_y_i,
  input  logic signed [vpc_pkg::COORD_W-1:0] block_z_i,
  input  logic signed [vpc_pkg::COORD_W-1:0] place_x_i,
  input  logic signed [vpc_pkg::COORD_W-1:0] place_y_i,
  input  logic signed [vpc_pkg::COORD_W-1:0] place_z_i,
  input  logic        [vpc_pkg::BOX_W-1:0]   box_width_i,
  input  logic        [vpc_pkg::BOX_W-1:0]   box_height_i,
  input  logic        [vpc_pkg::BOX_W-1:0]   box_depth_i,
  output logic                               inside_o,
  output logic        [CELL_W-1:0]           cell_o
);

  localparam int unsigned FULL_W = vpc_pkg::addr_w(MAX_SIDE * MAX_SIDE * MAX_SIDE);
  localparam logic [5:0] SIDE_MAX = 6'(MAX_SIDE);

  logic [5:0] sx, sy, sz;
  logic [5:0] eff_w, eff_h, eff_d;
  logic       in_x, in_y, in_z;
  logic [FULL_W-1:0] idx_full;

  assign sx = {block_x_i[4], block_x_i} + {place_x_i[4], place_x_i};
  assign sy = {block_y_i[4], block_y_i} + {place_y_i[4], place_y_i};
  assign sz = {block_z_i[4], block_z_i} + {place_z_i[4], place_z_i};

  assign eff_w = ({1'b0, box_width_i}  > SIDE_MAX) ? SIDE_MAX : {1'b0, box_width_i};
  assign eff_h = ({1'b0, box_height_i} > SIDE_MAX) ? SIDE_MAX : {1'b0, box_height_i};
  assign eff_d = ({1'b0, box_depth_i}  > SIDE_MAX) ? SIDE_MAX : {1'b0, box_depth_i};

  assign in_x = !sx[5] && ({1'b0, sx[4:0]} < eff_w);
  assign in_y = !sy[5] && ({1'b0, sy[4:0]} < eff_h);
  assign in_z = !sz[5] && ({1'b0, sz[4:0]} < eff_d);

  assign idx_full = FULL_W'(sz[4:0]) * FULL_W'(MAX_SIDE * MAX_SIDE)
                  + FULL_W'(sy[4:0]) * FULL_W'(MAX_SIDE)
                  + FULL_W'(sx[4:0]);

  assign inside_o = in_x && in_y && in_z && (32'(idx_full) < 32'(GRID_CELLS));
  assign cell_o   = CELL_W'(idx_full);

endmodule

FILE: sv/voxel_placement_checker_core.sv
// Voxel placement checker: occupancy map, pending piece buffer and placed-piece stack.
// A block item without last_block is buffered, or flagged if it lies outside the box
// or the buffer is full. In a commit each buffered block needs one pending-buffer read
// and one read-modify-write of the occupancy map; an overlap found at a block releases
// the cells already marked. A commit rejected for box or capacity and a pop with an
// empty stack go straight to the result; a pop of a piece makes one occupancy write per
// block. After reset the occupancy map is swept clear, one cell a cycle, before the
// first item is taken; configuration writes are taken at any time.
module voxel_placement_checker_core #(
  parameter int unsigned MAX_SIDE   = vpc_pkg::MAX_SIDE,
  parameter int unsigned GRID_CELLS = vpc_pkg::GRID_CELLS,
  parameter int unsigned MAX_BLOCKS = vpc_pkg::MAX_BLOCKS,
  parameter int unsigned MAX_PIECES = vpc_pkg::MAX_PIECES
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic        [vpc_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic        [vpc_pkg::BOX_W-1:0]      cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 kind_i,
  input  logic signed [vpc_pkg::COORD_W-1:0]    block_x_i,
  input  logic signed [vpc_pkg::COORD_W-1:0]    block_y_i,
  input  logic signed [vpc_pkg::COORD_W-1:0]    block_z_i,
  input  logic signed [vpc_pkg::COORD_W-1:0]    place_x_i,
  input  logic signed [vpc_pkg::COORD_W-1:0]    place_y_i,
  input  logic signed [vpc_pkg::COORD_W-1:0]    place_z_i,
  input  logic                                 last_block_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic        [vpc_pkg::STATUS_W-1:0]   status_o,
  output logic        [vpc_pkg::PIECES_W-1:0]   pieces_placed_o
);

  localparam int unsigned CELL_W = vpc_pkg::addr_w(GRID_CELLS);
  localparam int unsigned CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned PA_W   = vpc_pkg::addr_w(MAX_BLOCKS);
  localparam int unsigned ST_W   = $clog2(MAX_PIECES + 1);
  localparam int unsigned SA_W   = vpc_pkg::addr_w(MAX_PIECES);
  localparam int unsigned PL_W   = vpc_pkg::addr_w(MAX_PIECES * MAX_BLOCKS);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_C_RDP,
    S_C_RDO,
    S_C_CHK,
    S_R_WR,
    S_P_SZ,
    S_P_WR,
    S_DONE
  } state_e;

  state_e                       state_q, state_d;
  logic [CELL_W-1:0]            clr_q, clr_d;
  logic [CNT_W-1:0]             i_q, i_d;
  logic [CNT_W-1:0]             n_q, n_d;
  logic [CELL_W-1:0]            cell_q, cell_d;
  logic [PL_W-1:0]              base_q, base_d;
  logic [ST_W-1:0]              stack_q, stack_d;
  logic [CNT_W-1:0]             pend_cnt_q, pend_cnt_d;
  logic                         pend_out_q, pend_out_d;
  logic                         pend_ovf_q, pend_ovf_d;
  vpc_pkg::status_e             res_q, res_d;
  logic                         out_valid_q, out_valid_d;
  logic [vpc_pkg::STATUS_W-1:0] out_status_q, out_status_d;
  logic [vpc_pkg::PIECES_W-1:0] out_pieces_q, out_pieces_d;
  logic [vpc_pkg::BOX_W-1:0]    box_w_q, box_w_d;
  logic [vpc_pkg::BOX_W-1:0]    box_h_q, box_h_d;
  logic [vpc_pkg::BOX_W-1:0]    box_d_q, box_d_d;

  logic              blk_inside;
  logic [CELL_W-1:0] blk_cell;
  logic [CNT_W-1:0]  i_inc;
  logic [ST_W-1:0]   top;
  logic              cnt_full;

  logic              occ_we, occ_wdata, occ_rdata;
  logic [CELL_W-1:0] occ_waddr, occ_raddr;
  logic              pend_we;
  logic [PA_W-1:0]   pend_waddr, pend_raddr;
  logic [CELL_W-1:0] pend_rdata;
  logic              pl_we;
  logic [PL_W-1:0]   pl_waddr, pl_raddr;
  logic [CELL_W-1:0] pl_rdata;
  logic              sz_we;
  logic [SA_W-1:0]   sz_waddr, sz_raddr;
  logic [CNT_W-1:0]  sz_rdata;

  vpc_cell #(
    .MAX_SIDE   (MAX_SIDE),
    .GRID_CELLS (GRID_CELLS)
  ) u_cell (
    .block_x_i    (block_x_i),
    .block_y_i    (block_y_i),
    .block_z_i    (block_z_i),
    .place_x_i    (place_x_i),
    .place_y_i    (place_y_i),
    .place_z_i    (place_z_i),
    .box_width_i  (box_w_q),
    .box_height_i (box_h_q),
    .box_depth_i  (box_d_q),
    .inside_o     (blk_inside),
    .cell_o       (blk_cell)
  );

  vpc_ram #(.WIDTH(1), .DEPTH(GRID_CELLS)) u_occ_ram (
    .clk_i   (clk_i),
    .we_i    (occ_we),
    .waddr_i (occ_waddr),
    .wdata_i (occ_wdata),
    .raddr_i (occ_raddr),
    .rdata_o (occ_rdata)
  );

  vpc_ram #(.WIDTH(CELL_W), .DEPTH(MAX_BLOCKS)) u_pend_ram (
    .clk_i   (clk_i),
    .we_i    (pend_we),
    .waddr_i (pend_waddr),
    .wdata_i (blk_cell),
    .raddr_i (pend_raddr),
    .rdata_o (pend_rdata)
  );

  vpc_ram #(.WIDTH(CELL_W), .DEPTH(MAX_PIECES * MAX_BLOCKS)) u_placed_ram (
    .clk_i   (clk_i),
    .we_i    (pl_we),
    .waddr_i (pl_waddr),
    .wdata_i (cell_q),
    .raddr_i (pl_raddr),
    .rdata_o (pl_rdata)
  );

  vpc_ram #(.WIDTH(CNT_W), .DEPTH(MAX_PIECES)) u_size_ram (
    .clk_i   (clk_i),
    .we_i    (sz_we),
    .waddr_i (sz_waddr),
    .wdata_i (n_q),
    .raddr_i (sz_raddr),
    .rdata_o (sz_rdata)
  );

  assign i_inc    = i_q + CNT_W'(1);
  assign top      = stack_q - ST_W'(1);
  assign cnt_full = (pend_cnt_q == CNT_W'(MAX_BLOCKS));

  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign pieces_placed_o = out_pieces_q;

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    i_d          = i_q;
    n_d          = n_q;
    cell_d       = cell_q;
    base_d       = base_q;
    stack_d      = stack_q;
    pend_cnt_d   = pend_cnt_q;
    pend_out_d   = pend_out_q;
    pend_ovf_d   = pend_ovf_q;
    res_d        = res_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_pieces_d = out_pieces_q;
    box_w_d      = box_w_q;
    box_h_d      = box_h_q;
    box_d_d      = box_d_q;

    occ_we     = 1'b0;
    occ_waddr  = cell_q;
    occ_wdata  = 1'b0;
    occ_raddr  = pend_rdata;
    pend_we    = 1'b0;
    pend_waddr = pend_cnt_q[PA_W-1:0];
    pend_raddr = i_q[PA_W-1:0];
    pl_we      = 1'b0;
    pl_waddr   = base_q + PL_W'(i_q);
    pl_raddr   = base_q;
    sz_we      = 1'b0;
    sz_waddr   = stack_q[SA_W-1:0];
    sz_raddr   = top[SA_W-1:0];

    if (cfg_we_i) begin
      case (cfg_addr_i)
        vpc_pkg::REG_BOX_WIDTH:  box_w_d = cfg_wdata_i;
        vpc_pkg::REG_BOX_HEIGHT: box_h_d = cfg_wdata_i;
        vpc_pkg::REG_BOX_DEPTH:  box_d_d = cfg_wdata_i;
        default: ;
      endcase
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        occ_we    = 1'b1;
        occ_waddr = clr_q;
        occ_wdata = 1'b0;
        clr_d     = clr_q + CELL_W'(1);
        if (clr_q == CELL_W'(GRID_CELLS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          if (kind_i) begin
            if (stack_q == ST_W'(0)) begin
              res_d   = vpc_pkg::ST_NOTHING;
              state_d = S_DONE;
            end else begin
              base_d  = PL_W'(top) * PL_W'(MAX_BLOCKS);
              i_d     = CNT_W'(0);
              state_d = S_P_SZ;
            end
          end else begin
            if (!blk_inside) begin
              pend_out_d = 1'b1;
            end else if (cnt_full) begin
              pend_ovf_d = 1'b1;
            end else begin
              pend_we    = 1'b1;
              pend_cnt_d = pend_cnt_q + CNT_W'(1);
            end
            if (last_block_i) begin
              if (pend_out_d) begin
                res_d   = vpc_pkg::ST_OUT_OF_BOX;
                state_d = S_DONE;
              end else if (pend_ovf_d || stack_q == ST_W'(MAX_PIECES)) begin
                res_d   = vpc_pkg::ST_CAPACITY;
                state_d = S_DONE;
              end else begin
                base_d  = PL_W'(stack_q) * PL_W'(MAX_BLOCKS);
                i_d     = CNT_W'(0);
                n_d     = pend_cnt_d;
                state_d = S_C_RDP;
              end
              pend_cnt_d = CNT_W'(0);
              pend_out_d = 1'b0;
              pend_ovf_d = 1'b0;
            end
          end
        end
      end
      S_C_RDP: begin
        pend_raddr = i_q[PA_W-1:0];
        state_d    = S_C_RDO;
      end
      S_C_RDO: begin
        occ_raddr = pend_rdata;
        cell_d    = pend_rdata;
        state_d   = S_C_CHK;
      end
      S_C_CHK: begin
        if (occ_rdata) begin
          if (i_q == CNT_W'(0)) begin
            res_d   = vpc_pkg::ST_OVERLAP;
            state_d = S_DONE;
          end else begin
            pend_raddr = PA_W'(0);
            n_d        = i_q;
            i_d        = CNT_W'(0);
            state_d    = S_R_WR;
          end
        end else begin
          occ_we    = 1'b1;
          occ_waddr = cell_q;
          occ_wdata = 1'b1;
          pl_we     = 1'b1;
          pl_waddr  = base_q + PL_W'(i_q);
          if (i_inc == n_q) begin
            sz_we    = 1'b1;
            sz_waddr = stack_q[SA_W-1:0];
            stack_d  = stack_q + ST_W'(1);
            res_d    = vpc_pkg::ST_PLACED;
            state_d  = S_DONE;
          end else begin
            pend_raddr = i_inc[PA_W-1:0];
            i_d        = i_inc;
            state_d    = S_C_RDO;
          end
        end
      end
      S_R_WR: begin
        occ_we    = 1'b1;
        occ_waddr = pend_rdata;
        occ_wdata = 1'b0;
        if (i_inc == n_q) begin
          res_d   = vpc_pkg::ST_OVERLAP;
          state_d = S_DONE;
        end else begin
          pend_raddr = i_inc[PA_W-1:0];
          i_d        = i_inc;
        end
      end
      S_P_SZ: begin
        n_d      = sz_rdata;
        pl_raddr = base_q;
        if (sz_rdata == CNT_W'(0)) begin
          stack_d = top;
          res_d   = vpc_pkg::ST_REMOVED;
          state_d = S_DONE;
        end else begin
          state_d = S_P_WR;
        end
      end
      S_P_WR: begin
        occ_we    = 1'b1;
        occ_waddr = pl_rdata;
        occ_wdata = 1'b0;
        if (i_inc == n_q) begin
          stack_d = top;
          res_d   = vpc_pkg::ST_REMOVED;
          state_d = S_DONE;
        end else begin
          pl_raddr = base_q + PL_W'(i_inc);
          i_d      = i_inc;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_q;
          out_pieces_d = vpc_pkg::PIECES_W'(stack_q);
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      i_q          <= '0;
      n_q          <= '0;
      cell_q       <= '0;
      base_q       <= '0;
      stack_q      <= '0;
      pend_cnt_q   <= '0;
      pend_out_q   <= 1'b0;
      pend_ovf_q   <= 1'b0;
      res_q        <= vpc_pkg::ST_PLACED;
      out_valid_q  <= 1'b0;
      out_status_q <= '0;
      out_pieces_q <= '0;
      box_w_q      <= vpc_pkg::BOX_RESET;
      box_h_q      <= vpc_pkg::BOX_RESET;
      box_d_q      <= vpc_pkg::BOX_RESET;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      i_q          <= i_d;
      n_q          <= n_d;
      cell_q       <= cell_d;
      base_q       <= base_d;
      stack_q      <= stack_d;
      pend_cnt_q   <= pend_cnt_d;
      pend_out_q   <= pend_out_d;
      pend_ovf_q   <= pend_ovf_d;
      res_q        <= res_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_pieces_q <= out_pieces_d;
      box_w_q      <= box_w_d;
      box_h_q      <= box_h_d;
      box_d_q      <= box_d_d;
    end
  end

endmodule

FILE: sim/voxel_placement_checker_core_checker.sv
// Scoreboard for voxel_placement_checker_core: mirrors the occupancy map and checks every result.
`timescale 1ns / 100ps

module voxel_placement_checker_core_checker
  import vpc_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [BOX_W-1:0]          cfg_wdata_i,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic                      kind_i,
  input  logic signed [COORD_W-1:0] block_x_i,
  input  logic signed [COORD_W-1:0] block_y_i,
  input  logic signed [COORD_W-1:0] block_z_i,
  input  logic signed [COORD_W-1:0] place_x_i,
  input  logic signed [COORD_W-1:0] place_y_i,
  input  logic signed [COORD_W-1:0] place_z_i,
  input  logic                      last_block_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic [STATUS_W-1:0]       status_i,
  input  logic [PIECES_W-1:0]       pieces_placed_i,
  output int unsigned               fail_count_o,
  output int unsigned               awaiting_o
);

  localparam int unsigned CELL_W       = $clog2(GRID_CELLS);
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    status_e             status;
    logic [PIECES_W-1:0] pieces;
  } outcome_t;

  logic [BOX_W-1:0]  box_size      [3];
  bit                occupied_map  [GRID_CELLS];
  logic [CELL_W-1:0] open_cells    [MAX_BLOCKS];
  int unsigned       open_count;
  bit                open_outside;
  bit                open_overflow;
  logic [CELL_W-1:0] stacked_cells [MAX_PIECES*MAX_BLOCKS];
  int unsigned       stacked_size  [MAX_PIECES];
  int unsigned       stack_depth;
  outcome_t          outcome_q     [$];

  function automatic int clipped_side(logic [BOX_W-1:0] s);
    return (s > MAX_SIDE) ? MAX_SIDE : int'(s);
  endfunction

  function automatic void log_failure(string what);
    fail_count_o++;
    if (fail_count_o <= REPORT_LIMIT) $display("%0t: %s", $time, what);
  endfunction

  function automatic status_e commit_open_piece();
    int unsigned i;
    int unsigned j;
    int unsigned base;
    if (open_outside) return ST_OUT_OF_BOX;
    if (open_overflow || stack_depth >= MAX_PIECES) return ST_CAPACITY;
    for (i = 0; i < open_count; i++) begin
      if (occupied_map[open_cells[i]]) return ST_OVERLAP;
      for (j = 0; j < i; j++)
        if (open_cells[j] == open_cells[i]) return ST_OVERLAP;
    end
    base = stack_depth * MAX_BLOCKS;
    for (i = 0; i < open_count; i++) begin
      occupied_map[open_cells[i]] = 1'b1;
      stacked_cells[base + i] = open_cells[i];
    end
    stacked_size[stack_depth] = open_count;
    stack_depth++;
    return ST_PLACED;
  endfunction

  function automatic void apply_item(
    input logic                      pop,
    input logic signed [COORD_W-1:0] bx, by, bz, px, py, pz,
    input logic                      last
  );
    int          cx;
    int          cy;
    int          cz;
    int unsigned i;
    int unsigned base;
    status_e     st;
    if (pop) begin
      if (stack_depth == 0) begin
        st = ST_NOTHING;
      end else begin
        stack_depth--;
        base = stack_depth * MAX_BLOCKS;
        for (i = 0; i < stacked_size[stack_depth]; i++)
          occupied_map[stacked_cells[base + i]] = 1'b0;
        st = ST_REMOVED;
      end
    end else begin
      cx = int'(bx) + int'(px);
      cy = int'(by) + int'(py);
      cz = int'(bz) + int'(pz);
      if (cx < 0 || cy < 0 || cz < 0 ||
          cx >= clipped_side(box_size[REG_BOX_WIDTH]) ||
          cy >= clipped_side(box_size[REG_BOX_HEIGHT]) ||
          cz >= clipped_side(box_size[REG_BOX_DEPTH])) begin
        open_outside = 1'b1;
      end else if (open_count >= MAX_BLOCKS) begin
        open_overflow = 1'b1;
      end else begin
        open_cells[open_count] = CELL_W'((cz * MAX_SIDE + cy) * MAX_SIDE + cx);
        open_count++;
      end
      if (!last) return;
      st = commit_open_piece();
      open_count    = 0;
      open_outside  = 1'b0;
      open_overflow = 1'b0;
    end
    outcome_q.push_back('{status: st, pieces: PIECES_W'(stack_depth)});
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    outcome_t want;
    if (!rst_ni) begin
      box_size      = '{default: BOX_RESET};
      occupied_map  = '{default: 1'b0};
      open_count    = 0;
      open_outside  = 1'b0;
      open_overflow = 1'b0;
      stack_depth   = 0;
      outcome_q.delete();
      fail_count_o  = 0;
      awaiting_o    = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (outcome_q.size() == 0) begin
          log_failure($sformatf("unexpected result: status %0d pieces %0d",
                                status_i, pieces_placed_i));
        end else begin
          want = outcome_q.pop_front();
          if (status_i !== want.status || pieces_placed_i !== want.pieces)
            log_failure($sformatf("mismatch: expected status %0d pieces %0d, got %0d / %0d",
                                  want.status, want.pieces, status_i, pieces_placed_i));
        end
      end
      if (cfg_we_i && cfg_addr_i <= REG_BOX_DEPTH) box_size[cfg_addr_i] = cfg_wdata_i;
      if (in_valid_i && in_ready_i)
        apply_item(kind_i, block_x_i, block_y_i, block_z_i,
                   place_x_i, place_y_i, place_z_i, last_block_i);
      awaiting_o = outcome_q.size();
    end
  end

endmodule

FILE: sim/voxel_placement_checker_core_test.sv
// Testbench top for voxel_placement_checker_core: clock, reset, stimulus phases and verdict.
`timescale 1ns / 100ps

module voxel_placement_checker_core_test;
  import vpc_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 800000;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned HOLD_AT       = 120;
  localparam int unsigned HOLD_CYCLES   = 600;
  localparam int unsigned PHASES        = 9;

  typedef struct packed {
    logic               kind;
    logic [COORD_W-1:0] bx, by, bz, px, py, pz;
    logic               last;
  } txn_t;

  localparam txn_t POP_TXN = '{kind: 1'b1, default: '0};

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      cfg_we;
  cfg_reg_e                  cfg_addr;
  logic [BOX_W-1:0]          cfg_wdata;
  logic                      in_valid;
  logic                      in_ready;
  logic                      kind;
  logic signed [COORD_W-1:0] block_x, block_y, block_z;
  logic signed [COORD_W-1:0] place_x, place_y, place_z;
  logic                      last_block;
  logic                      out_valid;
  logic                      out_ready;
  logic [STATUS_W-1:0]       status;
  logic [PIECES_W-1:0]       pieces_placed;
  int unsigned               fail_count;
  int unsigned               awaiting;

  int unsigned tx_max = 18;
  int unsigned rx_max = 18;
  int unsigned items_sent = 0;
  int          box_dim [3] = '{16, 16, 16};

  voxel_placement_checker_core u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_addr_i     (cfg_addr),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .kind_i         (kind),
    .block_x_i      (block_x),
    .block_y_i      (block_y),
    .block_z_i      (block_z),
    .place_x_i      (place_x),
    .place_y_i      (place_y),
    .place_z_i      (place_z),
    .last_block_i   (last_block),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .status_o       (status),
    .pieces_placed_o(pieces_placed)
  );

  voxel_placement_checker_core_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_addr_i     (cfg_addr),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .kind_i         (kind),
    .block_x_i      (block_x),
    .block_y_i      (block_y),
    .block_z_i      (block_z),
    .place_x_i      (place_x),
    .place_y_i      (place_y),
    .place_z_i      (place_z),
    .last_block_i   (last_block),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .status_i       (status),
    .pieces_placed_i(pieces_placed),
    .fail_count_o   (fail_count),
    .awaiting_o     (awaiting)
  );

  always #6 clk = ~clk;

  function automatic txn_t block_txn(int bx, int by, int bz, int px, int py, int pz, bit last);
    txn_t t;
    t.kind = 1'b0;
    t.bx   = COORD_W'(bx);
    t.by   = COORD_W'(by);
    t.bz   = COORD_W'(bz);
    t.px   = COORD_W'(px);
    t.py   = COORD_W'(py);
    t.pz   = COORD_W'(pz);
    t.last = last;
    return t;
  endfunction

  // offset that lands the block inside the box along one axis
  function automatic logic [COORD_W-1:0] pick_offset(int p, int side, bit focal);
    int hi;
    int c;
    if (side == 0) return COORD_W'($urandom);
    hi = (p + 15 < side - 1) ? p + 15 : side - 1;
    if (focal && hi > 2) hi = 2;
    c = int'($urandom_range(hi, 0));
    return COORD_W'(c - p);
  endfunction

  task automatic send_item(input txn_t t);
    int unsigned gap;
    gap = $urandom_range(tx_max, 0);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    kind       <= t.kind;
    block_x    <= t.bx;
    block_y    <= t.by;
    block_z    <= t.bz;
    place_x    <= t.px;
    place_y    <= t.py;
    place_z    <= t.pz;
    last_block <= t.last;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_piece();
    int   n;
    int   k;
    int   a;
    int   p [3];
    bit   focal;
    txn_t t;
    n = ($urandom_range(99) < 8) ? int'($urandom_range(10, 9)) : int'($urandom_range(8, 1));
    focal = 1'($urandom_range(1));
    for (a = 0; a < 3; a++) p[a] = int'($urandom_range(30)) - 15;
    for (k = 0; k < n; k++) begin
      if (k > 0 && $urandom_range(99) < 4) send_item(POP_TXN);
      t.kind = 1'b0;
      t.px   = COORD_W'(p[0]);
      t.py   = COORD_W'(p[1]);
      t.pz   = COORD_W'(p[2]);
      if ($urandom_range(99) < 4) begin
        t.bx = COORD_W'($urandom);
        t.by = COORD_W'($urandom);
        t.bz = COORD_W'($urandom);
      end else begin
        t.bx = pick_offset(p[0], box_dim[0], focal);
        t.by = pick_offset(p[1], box_dim[1], focal);
        t.bz = pick_offset(p[2], box_dim[2], focal);
      end
      t.last = (k == n - 1);
      send_item(t);
    end
  endtask

  task automatic quiesce();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaiting != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin : result_drain
    int unsigned wait_left;
    int unsigned results_seen;
    out_ready    = 1'b0;
    wait_left    = 0;
    results_seen = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      out_ready <= (wait_left == 0);
      if (wait_left > 0) wait_left--;
      @(posedge clk);
      if (out_valid && out_ready) begin
        results_seen++;
        wait_left = (results_seen == HOLD_AT) ? HOLD_CYCLES : $urandom_range(rx_max, 0);
      end
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("[voxel_placement_checker_core] ERROR");
    $finish;
  end

  initial begin : stimulus
    int unsigned      ph;
    int unsigned      r;
    int unsigned      k;
    int unsigned      roll;
    int unsigned      budget;
    int unsigned      pop_pct;
    int unsigned      phase_start;
    logic [BOX_W-1:0] setting [3];
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_addr   = REG_BOX_WIDTH;
    cfg_wdata  = '0;
    in_valid   = 1'b0;
    kind       = 1'b0;
    block_x    = '0;
    block_y    = '0;
    block_z    = '0;
    place_x    = '0;
    place_y    = '0;
    place_z    = '0;
    last_block = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    send_item(POP_TXN);
    send_item(block_txn(0, 0, 0, 0, 0, 0, 1));
    send_item(block_txn(0, 0, 0, 0, 0, 0, 1));
    send_item(block_txn(15, 15, 15, 0, 0, 0, 1));
    send_item(block_txn(-16, -16, -16, 15, 15, 15, 1));
    send_item(block_txn(15, 0, 0, 15, 0, 0, 1));
    send_item(block_txn(1, 1, 1, 2, 2, 2, 0));
    send_item(block_txn(1, 1, 1, 2, 2, 2, 1));
    send_item(block_txn(-16, 0, 0, 0, 0, 0, 0));
    send_item(block_txn(0, 0, 0, 0, 0, 0, 1));
    send_item(block_txn(5, 0, 0, 0, 0, 0, 0));
    send_item(POP_TXN);
    send_item(block_txn(0, 5, 0, 0, 0, 0, 1));
    for (k = 0; k < 9; k++) send_item(block_txn(k, 0, 0, 0, 8, 8, k == 8));
    repeat (3) send_item(POP_TXN);

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          setting = '{16, 16, 16}; budget = 240; pop_pct = 10; tx_max = 18; rx_max = 18;
        end
        1: begin
          setting = '{1, 1, 1}; budget = 150; pop_pct = 30; tx_max = 0; rx_max = 0;
        end
        2: begin
          setting = '{31, 31, 31}; budget = 260; pop_pct = 4; tx_max = 18; rx_max = 18;
        end
        3: begin
          setting = '{0, 6, 6}; budget = 60; pop_pct = 20; tx_max = 18; rx_max = 0;
        end
        4: begin
          setting = '{4, 3, 2}; budget = 220; pop_pct = 25; tx_max = 3; rx_max = 18;
        end
        5: begin
          setting = '{16, 1, 8}; budget = 200; pop_pct = 15; tx_max = 18; rx_max = 18;
        end
        6: begin
          setting = '{9, 0, 31}; budget = 60; pop_pct = 20; tx_max = 0; rx_max = 18;
        end
        7: begin
          setting[0] = BOX_W'($urandom_range(16, 1));
          setting[1] = BOX_W'($urandom_range(16, 1));
          setting[2] = BOX_W'($urandom_range(16, 1));
          budget = 220; pop_pct = 20; tx_max = 18; rx_max = 18;
        end
        default: begin
          setting = '{2, 16, 17}; budget = 150; pop_pct = 15; tx_max = 18; rx_max = 3;
        end
      endcase
      if (ph > 0) begin
        quiesce();
        for (r = 0; r < 3; r++) begin
          @(negedge clk);
          cfg_we    <= 1'b1;
          cfg_addr  <= cfg_reg_e'(r);
          cfg_wdata <= setting[r];
        end
        @(negedge clk);
        cfg_we <= 1'b0;
      end
      for (r = 0; r < 3; r++) box_dim[r] = (setting[r] > MAX_SIDE) ? MAX_SIDE : int'(setting[r]);

      phase_start = items_sent;
      while (items_sent - phase_start < budget) begin
        roll = $urandom_range(99);
        if (roll < pop_pct) send_item(POP_TXN);
        else if (roll < pop_pct + 8) send_item(txn_t'($urandom));
        else send_piece();
      end
      // close any piece left open by stray blocks
      send_piece();
    end

    quiesce();
    if (fail_count == 0) $display("[voxel_placement_checker_core] OK");
    else $display("[voxel_placement_checker_core] ERROR");
    $finish;
  end

endmodule
